// ===== rtl/ile_pkg.sv =====
// Shared constants, codes and types of the indexed list engine.
package ile_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int FUNC_BITS = 3;
  localparam int POS_BITS  = 4;
  localparam int VAL_BITS  = 32;
  localparam int STAT_BITS = 2;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int IDX_BITS  = $clog2(DEPTH);

  // Request codes
  localparam logic [FUNC_BITS-1:0] FN_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_INSERT_AT  = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_GET_AT     = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_POP_BACK   = 3'd4;
  localparam logic [FUNC_BITS-1:0] FN_POP_FRONT  = 3'd5;
  localparam logic [FUNC_BITS-1:0] FN_REMOVE_AT  = 3'd6;

  // Result status codes
  localparam logic [STAT_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_BAD  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture request beat
    logic exec;   // apply operation, register result
  } dp_cmd_t;

endpackage

// ===== rtl/ile_ctrl.sv =====
// Controller state machine of the indexed list engine.
module ile_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ile_pkg::dp_cmd_t  cmd
);

  ile_pkg::state_t state;
  ile_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ile_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ile_pkg::S_IDLE: begin
        if (in_valid) state_next = ile_pkg::S_EXEC;
      end
      ile_pkg::S_EXEC: begin
        state_next = ile_pkg::S_RESP;
      end
      ile_pkg::S_RESP: begin
        if (out_ready) state_next = ile_pkg::S_IDLE;
      end
      default: state_next = ile_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state)
      ile_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ile_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      ile_pkg::S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/ile_dp.sv =====
// Datapath of the indexed list engine: request registers, shifting cell row, result.
module ile_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ile_pkg::dp_cmd_t                  cmd,
  input  logic [ile_pkg::FUNC_BITS-1:0]     func,
  input  logic [ile_pkg::POS_BITS-1:0]      position,
  input  logic [ile_pkg::VAL_BITS-1:0]      value,
  output logic [ile_pkg::VAL_BITS-1:0]      read_value,
  output logic [ile_pkg::STAT_BITS-1:0]     status,
  output logic [ile_pkg::CNT_BITS-1:0]      fill_count
);

  logic [ile_pkg::FUNC_BITS-1:0] req_func;
  logic [ile_pkg::POS_BITS-1:0]  req_pos;
  logic [ile_pkg::WORD_BITS-1:0] req_word;
  logic [ile_pkg::CNT_BITS-1:0]  used_count;
  logic [ile_pkg::WORD_BITS-1:0] cells [ile_pkg::DEPTH];

  logic [ile_pkg::CNT_BITS-1:0]  at;
  logic                          do_open;
  logic                          do_close;
  logic                          do_read;
  logic [ile_pkg::STAT_BITS-1:0] st_next;
  logic [ile_pkg::CNT_BITS-1:0]  used_count_next;
  logic [ile_pkg::WORD_BITS-1:0] sel_word;
  logic [ile_pkg::VAL_BITS-1:0]  read_value_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func <= func;
      req_pos  <= position;
      req_word <= ile_pkg::WORD_BITS'(value);
    end
  end

  // Decode: target index, status and which move the row makes
  always_comb begin
    at       = ile_pkg::CNT_BITS'(req_pos);
    do_open  = 1'b0;
    do_close = 1'b0;
    do_read  = 1'b0;
    st_next  = ile_pkg::ST_OK;
    unique case (req_func) inside
      ile_pkg::FN_PUSH_BACK, ile_pkg::FN_PUSH_FRONT, ile_pkg::FN_INSERT_AT: begin
        if (req_func == ile_pkg::FN_PUSH_BACK) at = used_count;
        else if (req_func == ile_pkg::FN_PUSH_FRONT) at = '0;
        if (at > used_count) st_next = ile_pkg::ST_BAD;
        else if (used_count >= ile_pkg::CNT_BITS'(ile_pkg::DEPTH)) st_next = ile_pkg::ST_FULL;
        else do_open = 1'b1;
      end
      ile_pkg::FN_GET_AT: begin
        if (at >= used_count) st_next = ile_pkg::ST_BAD;
        else do_read = 1'b1;
      end
      ile_pkg::FN_POP_BACK, ile_pkg::FN_POP_FRONT, ile_pkg::FN_REMOVE_AT: begin
        if (req_func == ile_pkg::FN_POP_BACK) at = used_count - 1'b1;
        else if (req_func == ile_pkg::FN_POP_FRONT) at = '0;
        if (used_count == '0) st_next = ile_pkg::ST_BAD;
        else if (at >= used_count) st_next = ile_pkg::ST_BAD;
        else do_close = 1'b1;
      end
      default: st_next = ile_pkg::ST_BAD;
    endcase
  end

  assign sel_word        = cells[at[ile_pkg::IDX_BITS-1:0]];
  assign read_value_next = (do_read || do_close) ? ile_pkg::VAL_BITS'(sel_word) : '0;

  always_comb begin
    used_count_next = used_count;
    if (do_open) used_count_next = used_count + 1'b1;
    else if (do_close) used_count_next = used_count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.exec) begin
      used_count <= used_count_next;
    end
  end

  // The cells from the target index up to the count move toward their neighbor in the same cycle
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < ile_pkg::DEPTH; i++) begin
        if (do_open) begin
          if (ile_pkg::CNT_BITS'(i) == at) begin
            cells[i] <= req_word;
          end else if (i > 0 && ile_pkg::CNT_BITS'(i) > at
                       && ile_pkg::CNT_BITS'(i) <= used_count) begin
            cells[i] <= cells[(i > 0) ? i - 1 : 0];
          end
        end else if (do_close) begin
          if (i < ile_pkg::DEPTH - 1 && ile_pkg::CNT_BITS'(i) >= at
              && ile_pkg::CNT_BITS'(i + 1) < used_count) begin
            cells[i] <= cells[(i < ile_pkg::DEPTH - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_value <= read_value_next;
      status     <= st_next;
      fill_count <= used_count_next;
    end
  end

endmodule

// ===== rtl/indexed_list_engine_unit.sv =====
// Top level of the indexed list engine: ordered word list with shifting insert and remove.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  request | in_valid / in_ready  | func[2:0], position[3:0], value[31:0]
//  result  | out_valid / out_ready| read_value[31:0], status[1:0], fill_count[4:0]
//
// One request is in flight at a time: accept beat, a single execute state, then the
// result beat waits in its register until taken; a result stall holds off the next
// request, as the controller runs its accept/execute/respond sequence.
// Any insert or remove finishes in the execute state: the affected cells shift at once.
// rst (synchronous) empties the list and returns the controller to idle; the
// cell contents are not cleared, only the count.
// A held result (out_ready low) keeps in_ready low until that beat is taken.
module indexed_list_engine_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ile_pkg::FUNC_BITS-1:0]  func,
  input  logic [ile_pkg::POS_BITS-1:0]   position,
  input  logic [ile_pkg::VAL_BITS-1:0]   value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ile_pkg::VAL_BITS-1:0]   read_value,
  output logic [ile_pkg::STAT_BITS-1:0]  status,
  output logic [ile_pkg::CNT_BITS-1:0]   fill_count
);

  ile_pkg::dp_cmd_t cmd;

  // Sequencing
  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // List storage and result registers
  ile_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (func),
    .position   (position),
    .value      (value),
    .read_value (read_value),
    .status     (status),
    .fill_count (fill_count)
  );

  // Request and result sides are never open together
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request accepted while a result is pending");

  // Every accepted request produces a result beat once the execute state has passed
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result beat missing after request");

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count <= ile_pkg::CNT_BITS'(ile_pkg::DEPTH)))
    else $error("fill count beyond capacity");

  // Full status only with a full list
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ile_pkg::ST_FULL)
      |-> (fill_count == ile_pkg::CNT_BITS'(ile_pkg::DEPTH)))
    else $error("full status on a list that is not full");

endmodule

// ===== bench/list_result_checker.sv =====
// Result checker for the indexed list engine: mirrors the list and compares result beats.
module list_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [ile_pkg::FUNC_BITS-1:0]  func,
  input  logic [ile_pkg::POS_BITS-1:0]   position,
  input  logic [ile_pkg::VAL_BITS-1:0]   value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [ile_pkg::VAL_BITS-1:0]   read_value,
  input  logic [ile_pkg::STAT_BITS-1:0]  status,
  input  logic [ile_pkg::CNT_BITS-1:0]   fill_count,
  output int                             errors,
  output int                             pending,
  output int                             checked,
  output int                             full_hits,
  output int                             bad_hits
);
  import ile_pkg::*;

  typedef struct packed {
    logic [VAL_BITS-1:0]  word;
    logic [STAT_BITS-1:0] st;
    logic [CNT_BITS-1:0]  fill;
  } list_result_t;

  logic [WORD_BITS-1:0] cells [DEPTH];
  logic [CNT_BITS-1:0]  used = '0;
  list_result_t         awaited [$];

  int fail_cnt  = 0;
  int match_cnt = 0;
  int full_cnt  = 0;
  int bad_cnt   = 0;
  int wait_cnt  = 0;

  assign errors    = fail_cnt;
  assign checked   = match_cnt;
  assign full_hits = full_cnt;
  assign bad_hits  = bad_cnt;
  assign pending   = wait_cnt;

  // Apply one request to the mirrored list and return the result it must produce.
  function automatic list_result_t apply_request(logic [FUNC_BITS-1:0] fn,
                                                 logic [POS_BITS-1:0] pos,
                                                 logic [VAL_BITS-1:0] word);
    list_result_t r;
    int at;
    int i;
    r      = '0;
    r.st   = ST_OK;
    case (fn)
      FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT_AT: begin
        at = (fn == FN_PUSH_BACK) ? int'(used) : (fn == FN_PUSH_FRONT) ? 0 : int'(pos);
        if (at > int'(used)) begin
          r.st = ST_BAD;
        end else if (int'(used) >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (i = int'(used); i > at; i--) cells[i] = cells[i-1];
          cells[at] = word[WORD_BITS-1:0];
          used = used + 1'b1;
        end
      end
      FN_GET_AT: begin
        if (int'(pos) >= int'(used)) r.st = ST_BAD;
        else r.word = cells[pos];
      end
      FN_POP_BACK, FN_POP_FRONT, FN_REMOVE_AT: begin
        if (used == '0) begin
          r.st = ST_BAD;
        end else begin
          at = (fn == FN_POP_BACK) ? int'(used) - 1 : (fn == FN_POP_FRONT) ? 0 : int'(pos);
          if (at >= int'(used)) begin
            r.st = ST_BAD;
          end else begin
            r.word = cells[at];
            for (i = at; i + 1 < int'(used); i++) cells[i] = cells[i+1];
            used = used - 1'b1;
          end
        end
      end
      default: r.st = ST_BAD;
    endcase
    r.fill = used;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (rst) begin
      used = '0;
      awaited.delete();
    end else begin
      // result beat first: it always belongs to an older request
      if (out_valid && out_ready) begin
        got.word = read_value;
        got.st   = status;
        got.fill = fill_count;
        if (awaited.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat with none expected: read_value %h status %0d fill %0d",
                   $time, got.word, got.st, got.fill);
        end else begin
          want = awaited.pop_front();
          match_cnt++;
          if (got.word !== want.word) begin
            fail_cnt++;
            $display("%0t: read_value expected %h actual %h", $time, want.word, got.word);
          end
          if (got.st !== want.st) begin
            fail_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          end
          if (got.fill !== want.fill) begin
            fail_cnt++;
            $display("%0t: fill_count expected %0d actual %0d", $time, want.fill, got.fill);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_request(func, position, value);
        if (want.st == ST_FULL) full_cnt++;
        if (want.st == ST_BAD) bad_cnt++;
        awaited.push_back(want);
      end
    end
    wait_cnt <= awaited.size();
  end

endmodule

// ===== bench/indexed_list_engine_unit_tb.sv =====
// Testbench top of the indexed list engine: request stimulus, pacing and verdict.
module indexed_list_engine_unit_tb;
  import ile_pkg::*;

  // func code the block does not define; must come back as a bad index
  localparam logic [FUNC_BITS-1:0] FN_UNUSED = 3'd7;
  // one item passes accept, execute and respond, plus gaps and stalls; this is many times the slowest run
  localparam int CYCLE_LIMIT = 400000;

  // bias of the random request mix: grow the list, shrink it, or neither
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [FUNC_BITS-1:0]  func       = FN_PUSH_BACK;
  logic [POS_BITS-1:0]   position   = '0;
  logic [VAL_BITS-1:0]   value      = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [VAL_BITS-1:0]   read_value;
  logic [STAT_BITS-1:0]  status;
  logic [CNT_BITS-1:0]   fill_count;

  int errors;
  int pending;
  int checked;
  int full_hits;
  int bad_hits;

  int cycles    = 0;
  int sent      = 0;
  int gap_pct   = 0;  // chance per cycle that the sender holds off
  int stall_pct = 0;  // chance per cycle that the receiver holds out_ready low

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  indexed_list_engine_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .status     (status),
    .fill_count (fill_count)
  );

  list_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value),
    .status     (status),
    .fill_count (fill_count),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits),
    .bad_hits   (bad_hits)
  );

  // Receiver: random back-pressure on the result channel, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("indexed_list_engine_unit test failed");
      $finish;
    end
  end

  // Present one request beat and hold it until accepted. Called right after a
  // rising edge, so every drive lands in that step; valid stays high between
  // back-to-back beats unless a gap is drawn.
  task automatic send_req(input logic [FUNC_BITS-1:0] fn,
                          input logic [POS_BITS-1:0]  pos,
                          input logic [VAL_BITS-1:0]  word);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= fn;
    position <= pos;
    value    <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Stop sending and wait until every result beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random request; the mix decides whether the list tends to fill or empty.
  task automatic send_random(input op_mix_t mix);
    logic [FUNC_BITS-1:0] fn;
    logic [VAL_BITS-1:0]  word;
    int                   pick;
    pick = $urandom_range(99);
    case (mix)
      MIX_GROW:   fn = (pick < 80) ? FUNC_BITS'($urandom_range(2))
                                   : FUNC_BITS'($urandom_range(6, 3));
      MIX_SHRINK: fn = (pick < 80) ? FUNC_BITS'($urandom_range(6, 4))
                                   : FUNC_BITS'($urandom_range(3));
      default:    fn = FUNC_BITS'($urandom_range(6));
    endcase
    // mostly random words, now and then the all-zero and all-one extremes
    case ($urandom_range(15))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    send_req(fn, POS_BITS'($urandom_range(15)), word);
  endtask

  initial begin : stimulus
    int ph;
    int seg;
    int n;
    op_mix_t seg_mix [4];
    int      seg_len [4];

    seg_mix = '{MIX_GROW, MIX_EVEN, MIX_SHRINK, MIX_EVEN};
    seg_len = '{30, 28, 30, 24};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: every pop, remove and read and an insert on the empty list, index checks on both sides,
    // append at index == count, the extremes of each field, the unused code.
    send_req(FN_POP_BACK,   4'd0,  32'h0);
    send_req(FN_POP_FRONT,  4'd0,  32'h0);
    send_req(FN_REMOVE_AT,  4'd0,  32'h0);
    send_req(FN_GET_AT,     4'd0,  32'h0);
    send_req(FN_INSERT_AT,  4'd1,  32'hFFFF_FFFF);  // index past count on empty list
    send_req(FN_INSERT_AT,  4'd0,  32'h0000_0000);
    send_req(FN_PUSH_BACK,  4'd15, 32'hFFFF_FFFF);
    send_req(FN_PUSH_FRONT, 4'd0,  32'hA5A5_5A5A);
    send_req(FN_INSERT_AT,  4'd3,  32'h0000_FFFF);  // index == count: append
    send_req(FN_GET_AT,     4'd15, 32'h0);          // past the end
    send_req(FN_GET_AT,     4'd3,  32'h0);
    send_req(FN_INSERT_AT,  4'd1,  32'h1234_5678);
    send_req(FN_REMOVE_AT,  4'd15, 32'h0);          // past the end, list nonempty
    send_req(FN_REMOVE_AT,  4'd2,  32'h0);
    send_req(FN_POP_FRONT,  4'd0,  32'h0);
    send_req(FN_POP_BACK,   4'd0,  32'h0);
    send_req(FN_UNUSED,     4'd9,  32'hDEAD_BEEF);

    // Random: four pacing phases, each growing the list to full, churning,
    // draining to empty and churning again. Each phase starts from a quiet block.
    for (ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0:       begin gap_pct = 0;  stall_pct <= 0;  end  // free-running
        1:       begin gap_pct = 72; stall_pct <= 0;  end  // sparse sender
        2:       begin gap_pct = 0;  stall_pct <= 72; end  // stalling receiver
        default: begin gap_pct = 12; stall_pct <= 12; end  // light idling on both
      endcase
      for (seg = 0; seg < 4; seg++) begin
        for (n = 0; n < seg_len[seg]; n++) send_random(seg_mix[seg]);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d requests and %0d result beats: %0d rejected as full, %0d bad index",
             sent, checked, full_hits, bad_hits);
    $display("Pacing: free-running, sparse sender, stalling receiver, light idling on both");
    if (errors == 0) begin
      $display("indexed_list_engine_unit test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("indexed_list_engine_unit test failed");
    end
    $finish;
  end

endmodule
